/* rtl/itp_pkg.sv */
// shared types, constants and codes of the iso-tp receive reassembler
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

    localparam int ID_W       = 11;
    localparam int LEN_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int NIB_W      = 4;
    localparam int CNT_W      = 3;
    localparam int DATA_BYTES = 7;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [ID_W-1:0]  OFFSET_RESET = 11'd8;
    localparam logic [CNT_W-1:0] CF_BYTES     = 3'd7;
    localparam logic [CNT_W-1:0] FF_BYTES     = 3'd6;
    localparam logic [LEN_W-1:0] MIN_FF_LEN   = 12'd8;

    localparam logic [NIB_W-1:0] TYPE_SF = 4'h0;
    localparam logic [NIB_W-1:0] TYPE_FF = 4'h1;
    localparam logic [NIB_W-1:0] TYPE_CF = 4'h2;

    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP = 2'd2;

    // what follows the data bytes of a job
    typedef enum logic [1:0] {
        TAIL_NONE = 2'b00,
        TAIL_FC   = 2'b01,
        TAIL_DROP = 2'b10
    } tail_t;

    typedef struct packed {
        logic [CNT_W-1:0]                  n_data;
        logic [DATA_BYTES-1:0][BYTE_W-1:0] data;
        logic [LEN_W-1:0]                  base_idx;
        logic [LEN_W-1:0]                  msg_len;
        logic                              end_msg;
        tail_t                             tail;
        logic [ID_W-1:0]                   reply_id;
    } job_t;

endpackage

`default_nettype wire

/* rtl/itp_if.sv */
// frame and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface itp_frame_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [10:0] frame_id;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;

    modport source (
        output valid, frame_ok, frame_id, byte0, byte1, byte2, byte3,
               byte4, byte5, byte6, byte7,
        input  ready
    );
    modport sink (
        input  valid, frame_ok, frame_id, byte0, byte1, byte2, byte3,
               byte4, byte5, byte6, byte7,
        output ready
    );
endinterface

interface itp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [10:0] reply_id;
    logic [11:0] byte_index;
    logic [11:0] message_length;
    logic        message_end;
    logic        last;

    modport source (
        output valid, kind, payload, reply_id, byte_index, message_length,
               message_end, last,
        input  ready
    );
    modport sink (
        input  valid, kind, payload, reply_id, byte_index, message_length,
               message_end, last,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/isotp_receive_reassembler.sv */
// top level of the iso-tp receive reassembler
//
//  channel   dir   handshake      carries
//  frame     in    valid/ready    frame_ok, frame_id, byte0..byte7
//  result    out   valid/ready    kind, payload, reply_id, byte_index,
//                                 message_length, message_end, last
//  cfg       in    cfg_we         cfg_wdata = reply_id_offset
//
// a frame is accepted whenever the job queue has room
// the back end sends one result item per cycle while result.ready allows, so a frame
// costs 1 to 7 result items there; its result count sets the sustained rate
// result items leave from a registered output stage, the queue lets the
// front keep accepting while the back end waits on result.ready
// reset clears the open message and sets reply_id_offset to 8
`timescale 1ns / 1ps
`default_nettype none

module isotp_receive_reassembler
    import itp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [ID_W-1:0] cfg_wdata,
    itp_frame_if.sink            frame,
    itp_result_if.source         result
);

    job_t front_job;
    logic front_push;
    logic q_full;
    job_t q_job;
    logic q_valid;
    logic q_pop;

    itp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .frame     (frame),
        .job       (front_job),
        .job_push  (front_push),
        .job_full  (q_full)
    );

    itp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_job   (front_job),
        .push     (front_push),
        .full     (q_full),
        .rd_job   (q_job),
        .rd_valid (q_valid),
        .pop      (q_pop)
    );

    itp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_job   (q_job),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

/* rtl/itp_front.sv */
// front end: accepts frames, classifies them, tracks the open message
`timescale 1ns / 1ps
`default_nettype none

module itp_front
    import itp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [ID_W-1:0]   cfg_wdata,
    itp_frame_if.sink              frame,
    output job_t                   job,
    output logic                   job_push,
    input  wire logic              job_full
);

    logic [ID_W-1:0]  offset_reg;
    logic             receiving_reg, receiving_next;
    logic [LEN_W-1:0] exp_len_reg, exp_len_next;
    logic [LEN_W-1:0] rcvd_reg, rcvd_next;

    logic                              accept;
    logic [NIB_W-1:0]                  ftype;
    logic [NIB_W-1:0]                  low;
    logic [DATA_BYTES-1:0][BYTE_W-1:0] data_d1;
    logic [DATA_BYTES-1:0][BYTE_W-1:0] data_d2;
    logic [LEN_W-1:0]                  rem;
    logic [CNT_W-1:0]                  n_cf;
    logic [CNT_W-1:0]                  n_sf;
    logic [LEN_W-1:0]                  ff_len;
    logic [LEN_W-1:0]                  rcvd_sum;

    assign frame.ready = !job_full;
    assign accept      = frame.valid && frame.ready;
    assign job_push    = accept;

    always_comb
    begin
        ftype   = frame.byte0[7:4];
        low     = frame.byte0[3:0];
        data_d1 = {frame.byte7, frame.byte6, frame.byte5, frame.byte4,
                   frame.byte3, frame.byte2, frame.byte1};
        data_d2 = {8'h00, frame.byte7, frame.byte6, frame.byte5,
                   frame.byte4, frame.byte3, frame.byte2};
        rem     = exp_len_reg - rcvd_reg;
        n_cf    = (rem < LEN_W'(CF_BYTES)) ? rem[CNT_W-1:0] : CF_BYTES;
        n_sf    = low[3] ? CF_BYTES : low[CNT_W-1:0];
        ff_len  = {low, frame.byte1};
        rcvd_sum = rcvd_reg + LEN_W'(n_cf);

        job          = '0;
        job.tail     = TAIL_DROP;
        job.data     = data_d1;
        receiving_next = receiving_reg;
        exp_len_next   = exp_len_reg;
        rcvd_next      = rcvd_reg;

        if (!frame.frame_ok)
        begin
            job.tail = TAIL_DROP;
        end
        else if (receiving_reg)
        begin
            if (ftype == TYPE_CF)
            begin
                job.n_data   = n_cf;
                job.base_idx = rcvd_reg;
                job.msg_len  = exp_len_reg;
                job.end_msg  = (rem <= LEN_W'(CF_BYTES));
                job.tail     = (n_cf == '0) ? TAIL_DROP : TAIL_NONE;
                rcvd_next    = rcvd_sum;
                if (rcvd_sum >= exp_len_reg || n_cf == '0)
                begin
                    receiving_next = 1'b0;
                end
            end
        end
        else
        begin
            case (ftype)
                TYPE_SF:
                begin
                    if (n_sf != '0)
                    begin
                        job.n_data  = n_sf;
                        job.msg_len = LEN_W'(n_sf);
                        job.end_msg = 1'b1;
                        job.tail    = TAIL_NONE;
                    end
                end
                TYPE_FF:
                begin
                    if (ff_len >= MIN_FF_LEN)
                    begin
                        job.n_data     = FF_BYTES;
                        job.data       = data_d2;
                        job.msg_len    = ff_len;
                        job.tail       = TAIL_FC;
                        job.reply_id   = frame.frame_id - offset_reg;
                        exp_len_next   = ff_len;
                        rcvd_next      = LEN_W'(FF_BYTES);
                        receiving_next = 1'b1;
                    end
                end
                TYPE_CF:
                begin
                    // consecutive frame with no open message: seven raw bytes
                    job.n_data  = CF_BYTES;
                    job.msg_len = LEN_W'(CF_BYTES);
                    job.end_msg = 1'b1;
                    job.tail    = TAIL_NONE;
                end
                default:
                begin
                    job.tail = TAIL_DROP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= OFFSET_RESET;
            receiving_reg <= 1'b0;
            exp_len_reg   <= '0;
            rcvd_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                offset_reg <= cfg_wdata;
            end
            if (accept)
            begin
                receiving_reg <= receiving_next;
                exp_len_reg   <= exp_len_next;
                rcvd_reg      <= rcvd_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/itp_queue.sv */
// short job queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module itp_queue
    import itp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire job_t wr_job,
    input  wire logic push,
    output logic      full,
    output job_t      rd_job,
    output logic      rd_valid,
    input  wire logic pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    job_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_QW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/itp_back.sv */
// back end: walks a job and sends one result item per cycle while result.ready allows
`timescale 1ns / 1ps
`default_nettype none

module itp_back
    import itp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire job_t     q_job,
    input  wire logic     q_valid,
    output logic          q_pop,
    itp_result_if.source  result
);

    job_t             cur_reg;
    logic             cur_valid_reg;
    logic [CNT_W-1:0] step_reg;
    logic             out_valid_reg;

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0] payload_reg, payload_next;
    logic [ID_W-1:0]   reply_id_reg, reply_id_next;
    logic [LEN_W-1:0]  index_reg, index_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              end_reg, end_next;
    logic              last_reg;

    logic [CNT_W-1:0] total;
    logic             is_last;
    logic             adv;
    logic             fire;

    assign total   = cur_reg.n_data + CNT_W'(cur_reg.tail != TAIL_NONE);
    assign is_last = (step_reg == total - 1'b1);
    // output register is free or being drained this cycle
    assign adv     = !out_valid_reg || result.ready;
    assign fire    = adv && cur_valid_reg;
    assign q_pop   = q_valid && (!cur_valid_reg || (fire && is_last));

    always_comb
    begin
        kind_next     = KIND_DROP;
        payload_next  = '0;
        reply_id_next = '0;
        index_next    = '0;
        length_next   = '0;
        end_next      = 1'b0;
        if (step_reg < cur_reg.n_data)
        begin
            kind_next    = KIND_DATA;
            payload_next = cur_reg.data[step_reg];
            index_next   = cur_reg.base_idx + LEN_W'(step_reg);
            length_next  = cur_reg.msg_len;
            end_next     = cur_reg.end_msg && (step_reg == cur_reg.n_data - 1'b1);
        end
        else if (cur_reg.tail == TAIL_FC)
        begin
            kind_next     = KIND_FC;
            reply_id_next = cur_reg.reply_id;
            length_next   = cur_reg.msg_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_job;
        end
        if (fire)
        begin
            kind_reg     <= kind_next;
            payload_reg  <= payload_next;
            reply_id_reg <= reply_id_next;
            index_reg    <= index_next;
            length_reg   <= length_next;
            end_reg      <= end_next;
            last_reg     <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= '0;
            end
            else if (fire)
            begin
                step_reg <= is_last ? '0 : step_reg + 1'b1;
                if (is_last)
                begin
                    cur_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = kind_reg;
    assign result.payload        = payload_reg;
    assign result.reply_id       = reply_id_reg;
    assign result.byte_index     = index_reg;
    assign result.message_length = length_reg;
    assign result.message_end    = end_reg;
    assign result.last           = last_reg;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// testbench for the iso-tp receive reassembler: directed frame table, then random frames
`timescale 1ns / 1ps

module tb_top;
    import itp_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int PHASE_ITEMS  = 90;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic                   ok;
        logic [ID_W-1:0]        id;
        logic [0:7][BYTE_W-1:0] data;
    } can_frame_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload;
        logic [ID_W-1:0]   reply_id;
        logic [LEN_W-1:0]  byte_index;
        logic [LEN_W-1:0]  msg_len;
        logic              msg_end;
        logic              last;
    } rx_item_t;

    typedef struct packed {
        can_frame_t frame;
        logic       typed;
        rx_item_t   want;
    } dir_row_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [ID_W-1:0] cfg_wdata = '0;

    itp_frame_if  frame_if ();
    itp_result_if result_if ();

    isotp_receive_reassembler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .frame     (frame_if),
        .result    (result_if)
    );

    always #HALF_PERIOD clk = ~clk;

    // reassembly state as the block should hold it
    logic [ID_W-1:0]  fc_offset;
    logic             msg_open;
    logic [LEN_W-1:0] msg_len;
    logic [LEN_W-1:0] msg_rcvd;

    rx_item_t frame_items[$];
    rx_item_t rx_items_due[$];
    dir_row_t dir_tbl[$];

    int err_cnt = 0;
    int idle_cycles = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;

    function automatic rx_item_t mk_item(input logic [KIND_W-1:0] kind,
                                         input logic [BYTE_W-1:0] payload,
                                         input logic [ID_W-1:0] rid,
                                         input logic [LEN_W-1:0] idx,
                                         input logic [LEN_W-1:0] mlen,
                                         input logic mend,
                                         input logic last);
        rx_item_t r;
        r.kind       = kind;
        r.payload    = payload;
        r.reply_id   = rid;
        r.byte_index = idx;
        r.msg_len    = mlen;
        r.msg_end    = mend;
        r.last       = last;
        return r;
    endfunction

    // fills frame_items with what one accepted frame must produce
    function automatic void reassemble(input can_frame_t f);
        logic [NIB_W-1:0]  ftype;
        logic [LEN_W-1:0]  rem;
        logic [LEN_W-1:0]  len;
        logic [ID_W-1:0]   rid;
        int                n;
        frame_items.delete();
        ftype = f.data[0][7:4];
        if (!f.ok)
        begin
            frame_items.push_back(mk_item(KIND_DROP, '0, '0, '0, '0, 1'b0, 1'b0));
        end
        else if (msg_open)
        begin
            if (ftype == TYPE_CF)
            begin
                rem = msg_len - msg_rcvd;
                n = (rem < CF_BYTES) ? int'(rem) : int'(CF_BYTES);
                for (int i = 0; i < n; i++)
                    frame_items.push_back(mk_item(KIND_DATA, f.data[1+i], '0,
                                                  msg_rcvd + LEN_W'(i), msg_len,
                                                  (i + 1 == n) && (n == rem), 1'b0));
                msg_rcvd = msg_rcvd + LEN_W'(n);
                if (msg_rcvd >= msg_len)
                    msg_open = 1'b0;
                if (n == 0)
                begin
                    msg_open = 1'b0;
                    frame_items.push_back(mk_item(KIND_DROP, '0, '0, '0, '0, 1'b0, 1'b0));
                end
            end
            else
            begin
                frame_items.push_back(mk_item(KIND_DROP, '0, '0, '0, '0, 1'b0, 1'b0));
            end
        end
        else if (ftype == TYPE_SF)
        begin
            n = int'(f.data[0][3:0]);
            if (n > CF_BYTES)
                n = int'(CF_BYTES);
            if (n == 0)
                frame_items.push_back(mk_item(KIND_DROP, '0, '0, '0, '0, 1'b0, 1'b0));
            for (int i = 0; i < n; i++)
                frame_items.push_back(mk_item(KIND_DATA, f.data[1+i], '0, LEN_W'(i),
                                              LEN_W'(n), i + 1 == n, 1'b0));
        end
        else if (ftype == TYPE_FF)
        begin
            len = {f.data[0][3:0], f.data[1]};
            if (len < MIN_FF_LEN)
            begin
                frame_items.push_back(mk_item(KIND_DROP, '0, '0, '0, '0, 1'b0, 1'b0));
            end
            else
            begin
                for (int i = 0; i < FF_BYTES; i++)
                    frame_items.push_back(mk_item(KIND_DATA, f.data[2+i], '0, LEN_W'(i),
                                                  len, 1'b0, 1'b0));
                rid = f.id - fc_offset;
                frame_items.push_back(mk_item(KIND_FC, '0, rid, '0, len, 1'b0, 1'b0));
                msg_len  = len;
                msg_rcvd = LEN_W'(FF_BYTES);
                msg_open = 1'b1;
            end
        end
        else if (ftype == TYPE_CF)
        begin
            // consecutive frame with no open message: seven raw bytes
            for (int i = 0; i < CF_BYTES; i++)
                frame_items.push_back(mk_item(KIND_DATA, f.data[1+i], '0, LEN_W'(i),
                                              LEN_W'(CF_BYTES), i + 1 == CF_BYTES, 1'b0));
        end
        else
        begin
            frame_items.push_back(mk_item(KIND_DROP, '0, '0, '0, '0, 1'b0, 1'b0));
        end
        frame_items[frame_items.size()-1].last = 1'b1;
    endfunction

    function automatic can_frame_t random_frame();
        can_frame_t       f;
        int               pick;
        logic [LEN_W-1:0] len;
        f.ok = 1'b1;
        f.id = ID_W'($urandom_range(2047));
        for (int i = 0; i < 8; i++)
            f.data[i] = BYTE_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (msg_open)
        begin
            // mostly continuation, the rest is incomplete reads or random noise
            if (pick < 85)
                f.data[0] = {TYPE_CF, f.data[0][3:0]};
            else if (pick < 90)
                f.ok = 1'b0;
        end
        else if (pick < 40)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                len = LEN_W'($urandom_range(7));
            else if (pick < 5)
                len = LEN_W'($urandom_range(700, 81));
            else
                len = LEN_W'($urandom_range(80, 8));
            f.data[0] = {TYPE_FF, len[11:8]};
            f.data[1] = len[7:0];
        end
        else if (pick < 65)
        begin
            f.data[0] = {TYPE_SF, f.data[0][3:0]};
        end
        else if (pick < 75)
        begin
            f.data[0] = {TYPE_CF, f.data[0][3:0]};
        end
        else if (pick < 82)
        begin
            f.ok = 1'b0;
        end
        return f;
    endfunction

    function automatic void add_row(input logic ok, input logic [ID_W-1:0] id,
                                    input logic [63:0] bytes, input logic typed,
                                    input rx_item_t want);
        dir_row_t r;
        r.frame.ok   = ok;
        r.frame.id   = id;
        r.frame.data = bytes;
        r.typed      = typed;
        r.want       = want;
        dir_tbl.push_back(r);
    endfunction

    task automatic report_mismatch(input string what);
        if (err_cnt < PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
        err_cnt++;
    endtask

    task automatic check_item(input rx_item_t got, input rx_item_t want);
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.payload !== want.payload)
            report_mismatch($sformatf("payload %0h, want %0h", got.payload, want.payload));
        if (got.reply_id !== want.reply_id)
            report_mismatch($sformatf("reply_id %0h, want %0h", got.reply_id, want.reply_id));
        if (got.byte_index !== want.byte_index)
            report_mismatch($sformatf("byte_index %0d, want %0d",
                                      got.byte_index, want.byte_index));
        if (got.msg_len !== want.msg_len)
            report_mismatch($sformatf("message_length %0d, want %0d",
                                      got.msg_len, want.msg_len));
        if (got.msg_end !== want.msg_end)
            report_mismatch($sformatf("message_end %0b, want %0b", got.msg_end, want.msg_end));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    endtask

    // typed rows carry their own single expected item, the predictor still tracks state
    task automatic send_frame(input can_frame_t f, input logic typed, input rx_item_t want);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            frame_if.valid = 1'b0;
            repeat ($urandom_range(16)) @(negedge clk);
        end
        @(negedge clk);
        frame_if.frame_ok = f.ok;
        frame_if.frame_id = f.id;
        frame_if.byte0    = f.data[0];
        frame_if.byte1    = f.data[1];
        frame_if.byte2    = f.data[2];
        frame_if.byte3    = f.data[3];
        frame_if.byte4    = f.data[4];
        frame_if.byte5    = f.data[5];
        frame_if.byte6    = f.data[6];
        frame_if.byte7    = f.data[7];
        frame_if.valid    = 1'b1;
        do @(posedge clk); while (!frame_if.ready);
        reassemble(f);
        if (typed)
            rx_items_due.push_back(want);
        else
            foreach (frame_items[i]) rx_items_due.push_back(frame_items[i]);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        frame_if.valid = 1'b0;
        while (rx_items_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_offset(input logic [ID_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        fc_offset = value;
    endtask

    // result side: ready drops in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_if.ready = 1'b0;
        end
        else if (stall_pct > 0 && $urandom_range(99) < stall_pct)
        begin
            stall_left = $urandom_range(16);
            result_if.ready = 1'b0;
        end
        else
        begin
            result_if.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_mon
        rx_item_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = mk_item(result_if.kind, result_if.payload, result_if.reply_id,
                          result_if.byte_index, result_if.message_length,
                          result_if.message_end, result_if.last);
            if (rx_items_due.size() == 0)
                report_mismatch("result item with nothing expected");
            else
                check_item(got, rx_items_due.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int         phase_items;
        rx_item_t   drop;
        rx_item_t   none;
        frame_if.valid    = 1'b0;
        frame_if.frame_ok = 1'b0;
        frame_if.frame_id = '0;
        frame_if.byte0    = '0;
        frame_if.byte1    = '0;
        frame_if.byte2    = '0;
        frame_if.byte3    = '0;
        frame_if.byte4    = '0;
        frame_if.byte5    = '0;
        frame_if.byte6    = '0;
        frame_if.byte7    = '0;
        fc_offset = OFFSET_RESET;
        msg_open  = 1'b0;
        msg_len   = '0;
        msg_rcvd  = '0;

        drop = mk_item(KIND_DROP, '0, '0, '0, '0, 1'b0, 1'b1);
        none = '0;
        // incomplete read, extreme id and bytes
        add_row(1'b0, 11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, drop);
        // single frame of length zero
        add_row(1'b1, 11'h000, 64'h0000_0000_0000_0000, 1'b1, drop);
        add_row(1'b1, 11'h123, 64'h01FF_0000_0000_0000, 1'b1,
                mk_item(KIND_DATA, 8'hFF, '0, '0, 12'd1, 1'b1, 1'b1));
        add_row(1'b1, 11'h7FF, 64'h0711_2233_4455_6677, 1'b0, none);
        // length nibble above seven is clamped
        add_row(1'b1, 11'h055, 64'h0FA1_B2C3_D4E5_F600, 1'b0, none);
        // first frame shorter than eight bytes
        add_row(1'b1, 11'h100, 64'h1007_AAAA_AAAA_AAAA, 1'b1, drop);
        add_row(1'b1, 11'h200, 64'h3055_5555_5555_5555, 1'b1, drop);
        add_row(1'b1, 11'h201, 64'hFF00_0000_0000_0000, 1'b1, drop);
        // consecutive frame with no open message
        add_row(1'b1, 11'h7E0, 64'h2180_0102_0408_1020, 1'b0, none);
        // reply id wraps below zero
        add_row(1'b1, 11'h000, 64'h1008_0102_0304_0506, 1'b0, none);
        add_row(1'b1, 11'h001, 64'h0311_1111_1111_1111, 1'b1, drop);
        add_row(1'b0, 11'h001, 64'h2100_0000_0000_0000, 1'b1, drop);
        add_row(1'b1, 11'h002, 64'h2199_8877_6655_4433, 1'b0, none);
        add_row(1'b1, 11'h7FF, 64'h1014_0102_0304_0506, 1'b0, none);
        add_row(1'b1, 11'h7FF, 64'h2121_2223_2425_2627, 1'b0, none);
        // closes with exactly seven bytes left
        add_row(1'b1, 11'h7FF, 64'h2FF1_F2F3_F4F5_F6F7, 1'b0, none);
        // long message, finished by the random part
        add_row(1'b1, 11'h7FF, 64'h1100_0011_2233_4455, 1'b0, none);
        add_row(1'b1, 11'h600, 64'h1FFF_0000_0000_0000, 1'b1, drop);
        add_row(1'b1, 11'h600, 64'h2A00_FF00_FF00_FF00, 1'b0, none);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        gap_pct   = 20;
        stall_pct = 6;
        foreach (dir_tbl[i]) send_frame(dir_tbl[i].frame, dir_tbl[i].typed, dir_tbl[i].want);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    write_offset(11'h000);
                    gap_pct   = 25;
                    stall_pct = 8;
                end
                1:
                begin
                    write_offset(11'h7FF);
                    gap_pct   = 10;
                    stall_pct = 3;
                end
                2:
                begin
                    write_offset(ID_W'($urandom_range(2047)));
                    gap_pct   = 50;
                    stall_pct = 15;
                end
                default:
                begin
                    write_offset(ID_W'($urandom_range(2047)));
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS || msg_open)
            begin
                send_frame(random_frame(), 1'b0, none);
                phase_items++;
            end
            wait_drained();
        end

        if (err_cnt == 0 && rx_items_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/itp_pkg.sv
rtl/itp_if.sv
rtl/itp_front.sv
rtl/itp_queue.sv
rtl/itp_back.sv
rtl/isotp_receive_reassembler.sv
dv/tb_top.sv
